/* sv/pst_pkg.sv */
// ----------------------------------------------------------------------------
// Priority subscription table package
// Shared sizes, command and status codes, and the types passed between the
// table controller and its slot store.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int ENTRIES     = 16;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_SUBSCRIBE   = 2'd0,
    CMD_UNSUBSCRIBE = 2'd1,
    CMD_FIND        = 2'd2,
    CMD_HAS         = 2'd3
  } pst_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_NONE = 2'd2
  } pst_status_e;

  // One stored subscription.
  typedef struct packed {
    logic [31:0]        instrument;
    logic [31:0]        strategy;
    logic [3:0]         kind;
    logic signed [15:0] prio;
  } pst_entry_t;

  // Write request from the controller to the slot store.
  typedef struct packed {
    logic              en;
    logic              set_valid;
    logic              clr_valid;
    logic [SLOT_W-1:0] addr;
    pst_entry_t        entry;
  } pst_wr_t;

  // Captured command.
  typedef struct packed {
    pst_cmd_e           cmd;
    logic [31:0]        strategy_code;
    logic [31:0]        instrument_code;
    logic [3:0]         event_type;
    logic signed [15:0] prio;
  } pst_req_t;

  // One result transaction.
  typedef struct packed {
    pst_status_e        status;
    logic [31:0]        match_strategy;
    logic signed [15:0] match_prio;
    logic               is_last;
  } pst_res_t;

endpackage

/* sv/pst_if.sv */
// ----------------------------------------------------------------------------
// Priority subscription table channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
interface pst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        strategy_code;
  logic [31:0]        instrument_code;
  logic [3:0]         event_type;
  logic signed [15:0] prio;

  modport source (output valid, cmd, strategy_code, instrument_code, event_type, prio,
                  input ready);
  modport sink   (input valid, cmd, strategy_code, instrument_code, event_type, prio,
                  output ready);
endinterface

interface pst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        match_strategy;
  logic signed [15:0] match_prio;
  logic               is_last;

  modport source (output valid, status, match_strategy, match_prio, is_last,
                  input ready);
  modport sink   (input valid, status, match_strategy, match_prio, is_last,
                  output ready);
endinterface

/* sv/pst_store.sv */
// ----------------------------------------------------------------------------
// Priority subscription table slot store
// Synchronous slot memory with one registered read port, one write port, and
// per-slot valid flags that reset clears.
// ----------------------------------------------------------------------------
module pst_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [pst_pkg::SLOT_W-1:0] rd_addr_i,
  output pst_pkg::pst_entry_t        rd_entry_o,
  output logic                       rd_valid_o,
  input  pst_pkg::pst_wr_t           wr_i
);

  pst_pkg::pst_entry_t           mem [pst_pkg::ENTRIES];
  logic [pst_pkg::ENTRIES-1:0]   valid_q;
  pst_pkg::pst_entry_t           rd_entry_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.set_valid) begin
        valid_q[wr_i.addr] <= 1'b1;
      end else if (wr_i.clr_valid) begin
        valid_q[wr_i.addr] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

/* sv/priority_subscription_table.sv */
// ----------------------------------------------------------------------------
// Priority subscription table
// Keyed subscription store with subscribe, unsubscribe, has and ordered find.
// ----------------------------------------------------------------------------
// Commands arrive as transactions on in_i and results leave on out_o; both
// are valid/ready channels. A command is taken only while the block is idle
// and yields one or more result transactions, the final one marked is_last.
// All slots live in a synchronous memory that is read once per slot in a scan,
// one read per cycle. Subscribe, unsubscribe and has take one scan, then the
// result passes through the pending and result registers; the block takes
// the next command in the same cycle in which that result becomes valid.
// The write of a subscribe or unsubscribe happens at the end of the scan,
// before any later read is issued, so no forwarding is required.
// Find selects one match per scan: each scan returns the best subscriber that
// ranks below the one found before, by descending priority and then ascending
// slot. A find with n matches takes n + 1 scans; an empty find gives one
// result with status none.
// Reset clears the valid flag of every slot, so the table is empty at once.
// When the receiver stalls, the result register holds its transaction; the
// next scan still runs, but its result is not loaded until the held one is
// taken.
// ----------------------------------------------------------------------------
module priority_subscription_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_in_if.sink    in_i,
  pst_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Captured command (payload, no reset).
  pst_pkg::pst_req_t req_q, req_d;

  // Read sequencing.
  logic                       issue_q, issue_d;
  logic [pst_pkg::SLOT_W-1:0] addr_q, addr_d;
  logic                       rvld_q, rvld_d;
  logic [pst_pkg::SLOT_W-1:0] rslot_q, rslot_d;

  // Key lookup trackers.
  logic                       hit_found_q, hit_found_d;
  logic [pst_pkg::SLOT_W-1:0] hit_slot_q, hit_slot_d;
  logic                       free_found_q, free_found_d;
  logic [pst_pkg::SLOT_W-1:0] free_slot_q, free_slot_d;

  // Best candidate of the current find scan.
  logic                       best_found_q, best_found_d;
  logic [pst_pkg::SLOT_W-1:0] best_slot_q, best_slot_d;
  logic signed [15:0]         best_prio_q, best_prio_d;
  logic [31:0]                best_strat_q, best_strat_d;

  // Subscriber found by the previous scan; it also bounds the next scan.
  logic                       held_q, held_d;
  logic [pst_pkg::SLOT_W-1:0] held_slot_q, held_slot_d;
  logic signed [15:0]         held_prio_q, held_prio_d;
  logic [31:0]                held_strat_q, held_strat_d;

  logic [pst_pkg::CNT_W-1:0]  emit_cnt_q, emit_cnt_d;

  // Pending result and output register.
  pst_pkg::pst_res_t pend_q, pend_d;
  pst_pkg::pst_res_t res_q, res_d;
  logic              ov_q, ov_d;

  // Store ports.
  pst_pkg::pst_entry_t rd_entry;
  logic                rd_valid;
  logic                rd_en;
  pst_pkg::pst_wr_t    wr;

  // Per-entry compare results.
  logic key_match;
  logic full_match;
  logic cand;
  logic better;
  logic scan_end;

  pst_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (addr_q),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_i       (wr)
  );

  // Comparisons on the entry that the memory returns this cycle.
  always_comb begin
    key_match  = rd_valid && (rd_entry.instrument == req_q.instrument_code) &&
                 (rd_entry.kind == req_q.event_type);
    full_match = key_match && (rd_entry.strategy == req_q.strategy_code);
    // A find candidate ranks strictly after the subscriber already found.
    cand       = key_match &&
                 (!held_q || ($signed(rd_entry.prio) < held_prio_q) ||
                  (($signed(rd_entry.prio) == held_prio_q) && (rslot_q > held_slot_q)));
    // Strict compare keeps the lower slot among equal priorities.
    better     = cand && (!best_found_q || ($signed(rd_entry.prio) > best_prio_q));
    scan_end   = rvld_q && (rslot_q == pst_pkg::LAST_SLOT);
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    issue_d      = issue_q;
    addr_d       = addr_q;
    rvld_d       = 1'b0;
    rslot_d      = rslot_q;
    hit_found_d  = hit_found_q;
    hit_slot_d   = hit_slot_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    best_found_d = best_found_q;
    best_slot_d  = best_slot_q;
    best_prio_d  = best_prio_q;
    best_strat_d = best_strat_q;
    held_d       = held_q;
    held_slot_d  = held_slot_q;
    held_prio_d  = held_prio_q;
    held_strat_d = held_strat_q;
    emit_cnt_d   = emit_cnt_q;
    pend_d       = pend_q;
    res_d        = res_q;
    ov_d         = ov_q;
    rd_en        = 1'b0;
    wr           = '0;
    wr.addr      = hit_slot_q;
    wr.entry     = '{instrument: req_q.instrument_code, strategy: req_q.strategy_code,
                     kind: req_q.event_type, prio: req_q.prio};

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          req_d.cmd             = pst_pkg::pst_cmd_e'(in_i.cmd);
          req_d.strategy_code   = in_i.strategy_code;
          req_d.instrument_code = in_i.instrument_code;
          req_d.event_type      = in_i.event_type;
          req_d.prio            = in_i.prio;
          state_d      = ST_SCAN;
          issue_d      = 1'b1;
          addr_d       = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          best_found_d = 1'b0;
          held_d       = 1'b0;
          emit_cnt_d   = '0;
        end
      end

      ST_SCAN: begin
        if (issue_q) begin
          rd_en   = 1'b1;
          rvld_d  = 1'b1;
          rslot_d = addr_q;
          addr_d  = addr_q + 1'b1;
          if (addr_q == pst_pkg::LAST_SLOT) begin
            issue_d = 1'b0;
          end
        end

        if (rvld_q) begin
          if (full_match && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_slot_d  = rslot_q;
          end
          if (!rd_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = rslot_q;
          end
          if (better) begin
            best_found_d = 1'b1;
            best_slot_d  = rslot_q;
            best_prio_d  = $signed(rd_entry.prio);
            best_strat_d = rd_entry.strategy;
          end
        end

        if (scan_end) begin
          pend_d.match_strategy = '0;
          pend_d.match_prio     = '0;
          pend_d.is_last        = 1'b1;
          pend_d.status         = pst_pkg::STATUS_OK;
          state_d               = ST_EMIT;
          unique case (req_q.cmd)
            pst_pkg::CMD_SUBSCRIBE: begin
              if (hit_found_d) begin
                // Existing key: rewrite the slot with the new priority.
                wr.en   = 1'b1;
                wr.addr = hit_slot_d;
              end else if (free_found_d) begin
                wr.en        = 1'b1;
                wr.set_valid = 1'b1;
                wr.addr      = free_slot_d;
              end else begin
                pend_d.status = pst_pkg::STATUS_FULL;
              end
            end
            pst_pkg::CMD_UNSUBSCRIBE: begin
              if (hit_found_d) begin
                wr.clr_valid = 1'b1;
                wr.addr      = hit_slot_d;
              end else begin
                pend_d.status = pst_pkg::STATUS_NONE;
              end
            end
            pst_pkg::CMD_HAS: begin
              if (!hit_found_d) begin
                pend_d.status = pst_pkg::STATUS_NONE;
              end
            end
            pst_pkg::CMD_FIND: begin
              if (!held_q) begin
                if (best_found_d) begin
                  // First match found: keep it and scan again for its follower.
                  held_d       = 1'b1;
                  held_slot_d  = best_slot_d;
                  held_prio_d  = best_prio_d;
                  held_strat_d = best_strat_d;
                  state_d      = ST_SCAN;
                  issue_d      = 1'b1;
                  addr_d       = '0;
                  best_found_d = 1'b0;
                end else begin
                  pend_d.status = pst_pkg::STATUS_NONE;
                end
              end else begin
                // Release the held match; it is last when nothing follows it
                // or the result limit is reached.
                pend_d.match_strategy = held_strat_q;
                pend_d.match_prio     = held_prio_q;
                pend_d.is_last        = !best_found_d ||
                                        (emit_cnt_q == pst_pkg::CNT_W'(pst_pkg::MAX_RESULTS - 1));
                emit_cnt_d            = emit_cnt_q + 1'b1;
                held_slot_d           = best_slot_d;
                held_prio_d           = best_prio_d;
                held_strat_d          = best_strat_d;
              end
            end
            default: begin
              pend_d.status = pst_pkg::STATUS_NONE;
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d  = 1'b1;
          res_d = pend_q;
          if (pend_q.is_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d      = ST_SCAN;
            issue_d      = 1'b1;
            addr_d       = '0;
            best_found_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= 1'b0;
      addr_q       <= '0;
      rvld_q       <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      held_q       <= 1'b0;
      emit_cnt_q   <= '0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      addr_q       <= addr_d;
      rvld_q       <= rvld_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      best_found_q <= best_found_d;
      held_q       <= held_d;
      emit_cnt_q   <= emit_cnt_d;
      ov_q         <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rslot_q      <= rslot_d;
    hit_slot_q   <= hit_slot_d;
    free_slot_q  <= free_slot_d;
    best_slot_q  <= best_slot_d;
    best_prio_q  <= best_prio_d;
    best_strat_q <= best_strat_d;
    held_slot_q  <= held_slot_d;
    held_prio_q  <= held_prio_d;
    held_strat_q <= held_strat_d;
    pend_q       <= pend_d;
    res_q        <= res_d;
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.status         = res_q.status;
  assign out_o.match_strategy = res_q.match_strategy;
  assign out_o.match_prio     = res_q.match_prio;
  assign out_o.is_last        = res_q.is_last;

endmodule

/* sv/pst_checker.sv */
// ----------------------------------------------------------------------------
// Priority subscription table checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module pst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] match_strategy_i,
  input logic [15:0] match_prio_i,
  input logic        is_last_i
);

  // A command occupies the block: no second transaction right behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("command accepted while the previous one is in progress");

  // Only the defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((status_i == pst_pkg::STATUS_OK) ||
                     (status_i == pst_pkg::STATUS_FULL) ||
                     (status_i == pst_pkg::STATUS_NONE)))
    else $error("undefined status code");

  // A full or not-present result ends its command and carries no match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != pst_pkg::STATUS_OK)) |->
      (is_last_i && (match_strategy_i == '0) && (match_prio_i == '0)))
    else $error("non-ok result with match data or without last mark");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(match_strategy_i) &&
       $stable(match_prio_i) && $stable(is_last_i)))
    else $error("result changed while stalled");

endmodule

bind priority_subscription_table pst_checker u_pst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .match_strategy_i (out_o.match_strategy),
  .match_prio_i     (out_o.match_prio),
  .is_last_i        (out_o.is_last)
);

/* sim/priority_subscription_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority subscription table testbench
// Drives subscribe, unsubscribe, has and find commands into the table and
// checks every result transaction against a mirror of the table kept in a
// scoreboard. A short directed sequence fills the table, probes the full,
// update, absent-key and empty-find cases, and then a long random sequence
// works on a small set of keys so that hits, ties and multi-result finds stay
// common. Both channels idle and stall at random, with quiet stretches.
// ----------------------------------------------------------------------------
module priority_subscription_table_tb;

  // Idle cycles on both channels after which the run is declared hung. The
  // longest correct gap is two table scans before the first find result plus
  // the receiver stall and the sender gap, far below this value.
  localparam int WATCHDOG_LIMIT = 40 * pst_pkg::ENTRIES + 200;
  // Cycles to wait after the last expected result for anything unexpected.
  localparam int DRAIN_CYCLES   = 4 * pst_pkg::ENTRIES;
  localparam int RANDOM_ITEMS   = 480;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the slot table that predicts the result
  // transactions of each accepted command, and a queue of those results
  // waiting to be matched against the block's output.
  // --------------------------------------------------------------------------
  class subscription_scoreboard;
    bit                 mirror_valid [pst_pkg::ENTRIES];
    logic [31:0]        mirror_instrument [pst_pkg::ENTRIES];
    logic [31:0]        mirror_strategy [pst_pkg::ENTRIES];
    logic [3:0]         mirror_kind [pst_pkg::ENTRIES];
    logic signed [15:0] mirror_prio [pst_pkg::ENTRIES];
    pst_pkg::pst_res_t  expected_results [$];
    int                 errors;

    function new();
      foreach (mirror_valid[i]) begin
        mirror_valid[i]      = 1'b0;
        mirror_instrument[i] = '0;
        mirror_strategy[i]   = '0;
        mirror_kind[i]       = '0;
        mirror_prio[i]       = '0;
      end
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Slot holding the full key, or -1 when the key is not present.
    function int key_slot(logic [31:0] strategy, logic [31:0] instrument, logic [3:0] kind);
      for (int i = 0; i < pst_pkg::ENTRIES; i++) begin
        if (mirror_valid[i] && mirror_instrument[i] == instrument &&
            mirror_strategy[i] == strategy && mirror_kind[i] == kind) begin
          return i;
        end
      end
      return -1;
    endfunction

    function void push_result(pst_pkg::pst_status_e status, logic [31:0] strategy,
                              logic signed [15:0] prio, logic last);
      pst_pkg::pst_res_t r;
      r.status         = status;
      r.match_strategy = strategy;
      r.match_prio     = prio;
      r.is_last        = last;
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Update the mirror for one accepted command and queue its results.
    function void note_command(pst_pkg::pst_req_t req);
      int slot;
      int hits [$];
      int cur;
      int j;
      int n;
      slot = key_slot(req.strategy_code, req.instrument_code, req.event_type);
      case (req.cmd)
        pst_pkg::CMD_SUBSCRIBE: begin
          if (slot >= 0) begin
            // Known key: only the priority changes, the slot is kept.
            mirror_prio[slot] = req.prio;
            push_result(pst_pkg::STATUS_OK, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < pst_pkg::ENTRIES; i++) begin
              if (slot < 0 && !mirror_valid[i]) begin
                slot = i;
              end
            end
            if (slot >= 0) begin
              mirror_valid[slot]      = 1'b1;
              mirror_instrument[slot] = req.instrument_code;
              mirror_strategy[slot]   = req.strategy_code;
              mirror_kind[slot]       = req.event_type;
              mirror_prio[slot]       = req.prio;
              push_result(pst_pkg::STATUS_OK, '0, '0, 1'b1);
            end else begin
              push_result(pst_pkg::STATUS_FULL, '0, '0, 1'b1);
            end
          end
        end
        pst_pkg::CMD_UNSUBSCRIBE: begin
          if (slot >= 0) begin
            mirror_valid[slot] = 1'b0;
            push_result(pst_pkg::STATUS_OK, '0, '0, 1'b1);
          end else begin
            push_result(pst_pkg::STATUS_NONE, '0, '0, 1'b1);
          end
        end
        pst_pkg::CMD_HAS: begin
          if (slot >= 0) begin
            push_result(pst_pkg::STATUS_OK, '0, '0, 1'b1);
          end else begin
            push_result(pst_pkg::STATUS_NONE, '0, '0, 1'b1);
          end
        end
        default: begin
          // Find: matches in slot order, then a stable sort on descending
          // priority so that equal priorities keep ascending slot order.
          for (int i = 0; i < pst_pkg::ENTRIES; i++) begin
            if (mirror_valid[i] && mirror_instrument[i] == req.instrument_code &&
                mirror_kind[i] == req.event_type) begin
              hits.insert(hits.size(), i);
            end
          end
          for (int i = 1; i < hits.size(); i++) begin
            cur = hits[i];
            j   = i - 1;
            while (j >= 0 && mirror_prio[hits[j]] < mirror_prio[cur]) begin
              hits[j + 1] = hits[j];
              j--;
            end
            hits[j + 1] = cur;
          end
          n = (hits.size() > pst_pkg::MAX_RESULTS) ? pst_pkg::MAX_RESULTS : hits.size();
          if (n == 0) begin
            push_result(pst_pkg::STATUS_NONE, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              push_result(pst_pkg::STATUS_OK, mirror_strategy[hits[i]],
                          mirror_prio[hits[i]], (i == n - 1) ? 1'b1 : 1'b0);
            end
          end
        end
      endcase
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    task check_result(pst_pkg::pst_res_t got);
      pst_pkg::pst_res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d strategy=%h prio=%0d last=%b",
                         got.status, got.match_strategy, got.match_prio, got.is_last));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.match_strategy !== want.match_strategy) begin
        report($sformatf("match_strategy %h, expected %h",
                         got.match_strategy, want.match_strategy));
      end
      if (got.match_prio !== want.match_prio) begin
        report($sformatf("match_prio %0d, expected %0d", got.match_prio, want.match_prio));
      end
      if (got.is_last !== want.is_last) begin
        report($sformatf("is_last %b, expected %b", got.is_last, want.is_last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block under test.
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  // When set, neither side idles, which gives back-to-back stretches.
  logic quiet;

  pst_in_if  cmd_ch ();
  pst_out_if res_ch ();

  subscription_scoreboard sb = new();

  // Second instrument and event kind of the random key pool, drawn per run.
  logic [31:0] alt_instrument;
  logic [3:0]  alt_kind;
  int          idle_cycles = 0;

  priority_subscription_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Strategy codes used by the directed fill and by the random key pool, so
  // that random commands keep hitting the entries that the fill left behind.
  function automatic logic [31:0] strategy_code_of(int idx);
    return 32'h5A5A_0000 | 32'(idx);
  endfunction

  // Present one command on the command channel and hold it until the block
  // takes it. The valid is only lowered when a gap is actually drawn, so a
  // command that follows directly is never lowered and raised in one step.
  task automatic send_command(pst_pkg::pst_cmd_e cmd, logic [31:0] strategy,
                              logic [31:0] instrument, logic [3:0] kind,
                              logic signed [15:0] prio);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.cmd             <= cmd;
    cmd_ch.strategy_code   <= strategy;
    cmd_ch.instrument_code <= instrument;
    cmd_ch.event_type      <= kind;
    cmd_ch.prio            <= prio;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Result side: before each transaction the receiver stalls for a random
  // number of cycles, then holds ready high until a result is taken.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Monitor: both channels are sampled at the rising edge, before the
  // nonblocking updates of that edge land. Accepted commands feed the
  // scoreboard, accepted results are checked, and a watchdog counts the
  // cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    pst_pkg::pst_req_t req;
    pst_pkg::pst_res_t res;
    if (rst_n) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        req.cmd             = pst_pkg::pst_cmd_e'(cmd_ch.cmd);
        req.strategy_code   = cmd_ch.strategy_code;
        req.instrument_code = cmd_ch.instrument_code;
        req.event_type      = cmd_ch.event_type;
        req.prio            = cmd_ch.prio;
        sb.note_command(req);
      end
      if (res_ch.valid && res_ch.ready) begin
        res.status         = pst_pkg::pst_status_e'(res_ch.status);
        res.match_strategy = res_ch.match_strategy;
        res.match_prio     = res_ch.match_prio;
        res.is_last        = res_ch.is_last;
        sb.check_result(res);
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("priority_subscription_table_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int                 roll;
    pst_pkg::pst_cmd_e  cmd;
    logic [31:0]        strategy;
    logic [31:0]        instrument;
    logic [3:0]         kind;
    logic signed [15:0] prio;

    rst_n                  <= 1'b0;
    quiet                  <= 1'b0;
    cmd_ch.valid           <= 1'b0;
    cmd_ch.cmd             <= pst_pkg::CMD_SUBSCRIBE;
    cmd_ch.strategy_code   <= '0;
    cmd_ch.instrument_code <= '0;
    cmd_ch.event_type      <= '0;
    cmd_ch.prio            <= '0;
    alt_instrument          = $urandom;
    alt_kind                = 4'($urandom_range(0, 14));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot under one instrument and kind. The priorities cycle
    // through both extremes, zero and small values, so a full find returns
    // the largest run of results with ties among equal priorities.
    for (int i = 0; i < pst_pkg::ENTRIES; i++) begin
      case (i % 5)
        0:       prio = 16'sh7FFF;
        1:       prio = 16'sh8000;
        2:       prio = 16'sh0000;
        3:       prio = -16'sd1;
        default: prio = 16'sd1;
      endcase
      send_command(pst_pkg::CMD_SUBSCRIBE, strategy_code_of(i), 32'hFFFF_FFFF, 4'hF, prio);
    end
    // A new key into a full table is refused.
    send_command(pst_pkg::CMD_SUBSCRIBE, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 16'sh7FFF);
    send_command(pst_pkg::CMD_FIND, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF, 16'sh0000);
    // A known key only has its priority replaced, even with the table full.
    send_command(pst_pkg::CMD_SUBSCRIBE, strategy_code_of(3), 32'hFFFF_FFFF, 4'hF,
                 16'sh7FFF);
    send_command(pst_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 16'sh0000);
    send_command(pst_pkg::CMD_HAS, strategy_code_of(7), 32'hFFFF_FFFF, 4'hF, 16'sh0000);
    send_command(pst_pkg::CMD_HAS, strategy_code_of(7), 32'hFFFF_FFFF, 4'h0, 16'sh0000);
    send_command(pst_pkg::CMD_UNSUBSCRIBE, strategy_code_of(5), 32'hFFFF_FFFF, 4'hF,
                 16'sh0000);
    send_command(pst_pkg::CMD_UNSUBSCRIBE, strategy_code_of(5), 32'hFFFF_FFFF, 4'hF,
                 16'sh0000);
    // Nothing under this instrument yet: a single result with status none.
    send_command(pst_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000, 4'h0, 16'sh0000);
    // The freed slot is the lowest free one and takes the new key.
    send_command(pst_pkg::CMD_SUBSCRIBE, 32'h0000_0000, 32'h0000_0000, 4'h0, 16'sh8000);
    send_command(pst_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 16'sh0000);

    // Random part. Most commands draw their key from a small pool of two
    // instruments, two kinds and six strategies, so the table churns around
    // full and finds return several ordered matches. One command in ten is
    // noise with every field drawn over its whole range. Every third stretch
    // of forty commands runs with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= ((n / 40) % 3 == 2);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        cmd        = pst_pkg::pst_cmd_e'($urandom_range(0, 3));
        strategy   = $urandom;
        instrument = $urandom;
        kind       = 4'($urandom_range(0, 15));
        prio       = 16'($urandom);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          cmd = pst_pkg::CMD_SUBSCRIBE;
        end else if (roll < 62) begin
          cmd = pst_pkg::CMD_UNSUBSCRIBE;
        end else if (roll < 84) begin
          cmd = pst_pkg::CMD_FIND;
        end else begin
          cmd = pst_pkg::CMD_HAS;
        end
        strategy   = (cmd == pst_pkg::CMD_FIND) ? $urandom
                                                : strategy_code_of($urandom_range(0, 5));
        instrument = $urandom_range(0, 1) ? alt_instrument : 32'hFFFF_FFFF;
        kind       = $urandom_range(0, 1) ? alt_kind : 4'hF;
        // Priorities from a tiny set produce ties; extremes now and then.
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
          case ($urandom_range(0, 2))
            0:       prio = 16'sh0000;
            1:       prio = -16'sd1;
            default: prio = 16'sd7;
          endcase
        end else if (roll < 4) begin
          prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          prio = 16'($urandom);
        end
      end
      send_command(cmd, strategy, instrument, kind, prio);
    end
    cmd_ch.valid <= 1'b0;
    quiet        <= 1'b1;

    // Let the monitor note the last command, wait for every predicted
    // result, then give the block time to show anything it should not send.
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("priority_subscription_table_tb passed");
    end else begin
      $display("priority_subscription_table_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pst_pkg.sv
sv/pst_if.sv
sv/pst_store.sv
sv/priority_subscription_table.sv
sv/pst_checker.sv
sim/priority_subscription_table_tb.sv
